>>> src/ope_pkg.sv
package ope_pkg;

  localparam int ANGLE_ITERATIONS_DEF = 16;
  localparam int STATE_BITS_DEF       = 48;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_DAMPING       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OMEGA_SQUARED = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_MU    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_QUAD_GAIN     = 3'd4;

  localparam logic [31:0] DAMPING_RST   = 32'd7196286;
  localparam logic [31:0] OMEGA_SQ_RST  = 32'd75360;
  localparam logic [31:0] INV_MU_RST    = 32'd8589935;
  localparam logic [31:0] TIME_STEP_RST = 32'd268435456;
  localparam logic [31:0] QUAD_GAIN_RST = 32'd562209914;

  localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [15:0] PI_Q13      = 16'sd25736;

  typedef struct packed {
    logic [31:0] damping;
    logic [31:0] omega_squared;
    logic [31:0] inverse_mu;
    logic [31:0] time_step;
    logic [31:0] quadrature_gain;
  } cfg_t;

  // Arctangent of 2^-i in Q2.30.
  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

>>> src/ope_front.sv
module ope_front #(
  parameter int STATE_BITS = ope_pkg::STATE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic signed [31:0]           sample_i,
  input  logic                         restart_i,
  output logic                         avail_o,
  input  logic                         take_i,
  output logic signed [STATE_BITS-1:0] sample_o,
  output logic                         restart_o
);

  localparam int WW = STATE_BITS + 48;

  typedef struct packed {
    logic signed [STATE_BITS-1:0] s;
    logic                         restart;
  } entry_t;

  entry_t     mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  logic signed [WW-1:0] wide, maxv_w, minv_w;
  entry_t               new_e;

  // The sample is rescaled to Q16.32 and saturated to the state width.
  always_comb begin
    wide   = {{STATE_BITS{sample_i[31]}}, sample_i, 16'b0};
    maxv_w = WW'({1'b0, {(STATE_BITS-1){1'b1}}});
    minv_w = ~maxv_w;
    if (wide > maxv_w) begin
      new_e.s = {1'b0, {(STATE_BITS-1){1'b1}}};
    end else if (wide < minv_w) begin
      new_e.s = {1'b1, {(STATE_BITS-1){1'b0}}};
    end else begin
      new_e.s = wide[STATE_BITS-1:0];
    end
    new_e.restart = restart_i;
  end

  assign full      = (cnt_q == 2'd2);
  assign avail_o   = (cnt_q != 2'd0);
  assign do_push   = push && !full;
  assign do_pop    = take_i && avail_o;
  assign sample_o  = mem_q[rd_q].s;
  assign restart_o = mem_q[rd_q].restart;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= new_e;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

>>> src/ope_mulq.sv
module ope_mulq #(
  parameter int STATE_BITS = ope_pkg::STATE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [STATE_BITS-1:0] a_i,
  input  logic [31:0]                  b_i,
  input  logic                         sh28_i,
  output logic                         done_o,
  output logic signed [STATE_BITS-1:0] p_o
);

  localparam int NCH = (STATE_BITS + 31) / 32;
  localparam int MW  = NCH * 32;
  localparam int PW  = MW + 33;
  localparam int CW  = $clog2(NCH + 1);

  typedef enum logic [1:0] {IDLE, MUL, FIN} state_e;

  state_e          state_q;
  logic [CW-1:0]   cnt_q;
  logic [MW-1:0]   mag_q;
  logic [PW-1:0]   prod_q;
  logic [31:0]     b_q;
  logic            neg_q, sh28_q, done_q;
  logic signed [STATE_BITS-1:0] p_q, p_d;

  logic [STATE_BITS-1:0] abs_a;
  logic [PW-1:0]         rnd, q, maxv_w;
  logic [63:0]           part;

  assign abs_a = a_i[STATE_BITS-1] ? STATE_BITS'(-a_i) : a_i;
  assign part  = {32'd0, mag_q[MW-1 -: 32]} * {32'd0, b_q};

  // Round to nearest with ties away from zero on the magnitude, then saturate.
  always_comb begin
    rnd    = prod_q + (sh28_q ? PW'(1) << 27 : PW'(1) << 31);
    q      = sh28_q ? (rnd >> 28) : (rnd >> 32);
    maxv_w = PW'({1'b0, {(STATE_BITS-1){1'b1}}});
    if (neg_q) begin
      if (q > maxv_w + PW'(1)) p_d = {1'b1, {(STATE_BITS-1){1'b0}}};
      else p_d = -$signed(q[STATE_BITS-1:0]);
    end else begin
      if (q > maxv_w) p_d = {1'b0, {(STATE_BITS-1){1'b1}}};
      else p_d = q[STATE_BITS-1:0];
    end
  end

  assign done_o = done_q;
  assign p_o    = p_q;

  always_ff @(posedge clk_i) begin
    if (state_q == IDLE && start_i) begin
      mag_q  <= MW'(abs_a);
      b_q    <= b_i;
      neg_q  <= a_i[STATE_BITS-1];
      sh28_q <= sh28_i;
      prod_q <= '0;
    end else if (state_q == MUL) begin
      // High chunk first: one 32 by 32 partial product per cycle.
      prod_q <= (prod_q << 32) + PW'(part);
      mag_q  <= mag_q << 32;
    end
    if (state_q == FIN) p_q <= p_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        IDLE: begin
          if (start_i) begin
            state_q <= MUL;
            cnt_q   <= '0;
          end
        end
        MUL: begin
          cnt_q <= cnt_q + CW'(1);
          if (cnt_q == CW'(NCH - 1)) state_q <= FIN;
        end
        FIN: begin
          done_q  <= 1'b1;
          state_q <= IDLE;
        end
        default: state_q <= IDLE;
      endcase
    end
  end

endmodule

>>> src/ope_cordic.sv
module ope_cordic #(
  parameter int ANGLE_ITERATIONS = ope_pkg::ANGLE_ITERATIONS_DEF,
  parameter int STATE_BITS       = ope_pkg::STATE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [STATE_BITS-1:0] y_i,
  input  logic signed [STATE_BITS-1:0] x_i,
  output logic                         busy_o,
  output logic                         done_o,
  output logic signed [15:0]           phase_o
);

  localparam int IW = $clog2(ANGLE_ITERATIONS);

  typedef enum logic [1:0] {IDLE, NORM, ROT, FIN} state_e;

  state_e                state_q;
  logic [STATE_BITS-1:0] ax_q, ay_q;
  logic                  xneg_q, yneg_q, done_q;
  logic signed [33:0]    cx_q, cy_q, sx, sy;
  logic signed [35:0]    z_q, za;
  logic [IW-1:0]         i_q;
  logic signed [15:0]    phase_q, ph_d;
  logic signed [35:0]    z1, z2, r;

  always_comb begin
    sx = cx_q >>> i_q;
    sy = cy_q >>> i_q;
    za = 36'(ope_pkg::atan_q30(5'(i_q)));
  end

  always_comb begin
    z1 = xneg_q ? ope_pkg::PI_Q30 - z_q : z_q;
    z2 = yneg_q ? -z1 : z1;
    r  = (z2 + 36'sd65536) >>> 17;
    if (r > 36'(ope_pkg::PI_Q13)) ph_d = ope_pkg::PI_Q13;
    else if (r < -36'(ope_pkg::PI_Q13)) ph_d = -ope_pkg::PI_Q13;
    else ph_d = r[15:0];
  end

  assign busy_o  = (state_q != IDLE);
  assign done_o  = done_q;
  assign phase_o = phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
      done_q  <= 1'b0;
      i_q     <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        IDLE: begin
          if (start_i) begin
            yneg_q  <= y_i[STATE_BITS-1];
            xneg_q  <= x_i[STATE_BITS-1];
            ay_q    <= y_i[STATE_BITS-1] ? STATE_BITS'(-y_i) : y_i;
            ax_q    <= x_i[STATE_BITS-1] ? STATE_BITS'(-x_i) : x_i;
            state_q <= NORM;
          end
        end
        NORM: begin
          // Both magnitudes shift right together, one bit a cycle, until they fit 30 bits.
          if (((ax_q | ay_q) >> 30) != '0) begin
            ax_q <= ax_q >> 1;
            ay_q <= ay_q >> 1;
          end else if (ay_q == '0) begin
            z_q     <= '0;
            state_q <= FIN;
          end else if (ax_q == '0) begin
            z_q     <= ope_pkg::HALF_PI_Q30;
            state_q <= FIN;
          end else begin
            cx_q    <= 34'(ax_q[29:0]);
            cy_q    <= 34'(ay_q[29:0]);
            z_q     <= '0;
            i_q     <= '0;
            state_q <= ROT;
          end
        end
        ROT: begin
          if (cy_q > 0) begin
            cx_q <= cx_q + sy;
            cy_q <= cy_q - sx;
            z_q  <= z_q + za;
          end else begin
            cx_q <= cx_q - sy;
            cy_q <= cy_q + sx;
            z_q  <= z_q - za;
          end
          i_q <= i_q + IW'(1);
          if (i_q == IW'(ANGLE_ITERATIONS - 1)) state_q <= FIN;
        end
        FIN: begin
          phase_q <= ph_d;
          done_q  <= 1'b1;
          state_q <= IDLE;
        end
        default: state_q <= IDLE;
      endcase
    end
  end

  a_done_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (phase_q <= ope_pkg::PI_Q13 && phase_q >= -ope_pkg::PI_Q13))
    else $error("phase out of range");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("done held longer than one cycle");

  a_fin_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FIN) |=> (done_q && state_q == IDLE))
    else $error("finish did not deliver a result");

endmodule

>>> src/ope_core.sv
module ope_core #(
  parameter int ANGLE_ITERATIONS = ope_pkg::ANGLE_ITERATIONS_DEF,
  parameter int STATE_BITS       = ope_pkg::STATE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ope_pkg::cfg_t                cfg_i,
  input  logic                         avail_i,
  input  logic signed [STATE_BITS-1:0] sample_i,
  input  logic                         restart_i,
  output logic                         take_o,
  input  logic                         space_i,
  output logic                         res_valid_o,
  output logic signed [15:0]           phase_o
);

  localparam logic signed [STATE_BITS-1:0] MAXV = {1'b0, {(STATE_BITS-1){1'b1}}};
  localparam logic signed [STATE_BITS-1:0] MINV = {1'b1, {(STATE_BITS-1){1'b0}}};

  typedef enum logic [2:0] {IDLE, ISSUE, WAIT, CSTART, CWAIT, OUT} state_e;
  typedef enum logic [2:0] {
    ST_POS, ST_DAMP, ST_SPRING, ST_VEL, ST_LEAK, ST_INTEG, ST_GAIN
  } step_e;

  state_e state_q;
  step_e  step_q;

  logic signed [STATE_BITS-1:0] u_q, x_q, d_q, acc_q, s_q;
  logic signed [STATE_BITS-1:0] mul_a, mul_p;
  logic [31:0]                  mul_b;
  logic                         mul_sh28, mul_start, mul_done;
  logic                         cor_start, cor_busy, cor_done;
  logic signed [15:0]           cor_phase, phase_q;

  function automatic logic signed [STATE_BITS-1:0] sat_add(
    input logic signed [STATE_BITS-1:0] a, input logic signed [STATE_BITS-1:0] b);
    logic signed [STATE_BITS:0] s;
    s = {a[STATE_BITS-1], a} + {b[STATE_BITS-1], b};
    if (s[STATE_BITS] != s[STATE_BITS-1]) return s[STATE_BITS] ? MINV : MAXV;
    return s[STATE_BITS-1:0];
  endfunction

  function automatic logic signed [STATE_BITS-1:0] sat_sub(
    input logic signed [STATE_BITS-1:0] a, input logic signed [STATE_BITS-1:0] b);
    logic signed [STATE_BITS:0] s;
    s = {a[STATE_BITS-1], a} - {b[STATE_BITS-1], b};
    if (s[STATE_BITS] != s[STATE_BITS-1]) return s[STATE_BITS] ? MINV : MAXV;
    return s[STATE_BITS-1:0];
  endfunction

  always_comb begin
    mul_a    = x_q;
    mul_b    = cfg_i.time_step;
    mul_sh28 = 1'b1;
    case (step_q)
      ST_POS:    begin mul_a = x_q;   mul_b = cfg_i.time_step;       mul_sh28 = 1'b1; end
      ST_DAMP:   begin mul_a = x_q;   mul_b = cfg_i.damping;         mul_sh28 = 1'b0; end
      ST_SPRING: begin mul_a = u_q;   mul_b = cfg_i.omega_squared;   mul_sh28 = 1'b0; end
      ST_VEL:    begin mul_a = acc_q; mul_b = cfg_i.time_step;       mul_sh28 = 1'b1; end
      ST_LEAK:   begin mul_a = sat_sub(x_q, d_q); mul_b = cfg_i.inverse_mu; mul_sh28 = 1'b0; end
      ST_INTEG:  begin mul_a = acc_q; mul_b = cfg_i.time_step;       mul_sh28 = 1'b1; end
      ST_GAIN:   begin mul_a = d_q;   mul_b = cfg_i.quadrature_gain; mul_sh28 = 1'b1; end
      default:   begin mul_a = x_q;   mul_b = cfg_i.time_step;       mul_sh28 = 1'b1; end
    endcase
  end

  assign mul_start   = (state_q == ISSUE);
  assign cor_start   = (state_q == CSTART);
  assign take_o      = (state_q == IDLE) && avail_i;
  assign res_valid_o = (state_q == OUT) && space_i;
  assign phase_o     = phase_q;

  ope_mulq #(.STATE_BITS(STATE_BITS)) u_mulq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .sh28_i  (mul_sh28),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  ope_cordic #(.ANGLE_ITERATIONS(ANGLE_ITERATIONS), .STATE_BITS(STATE_BITS)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .y_i     (acc_q),
    .x_i     (x_q),
    .busy_o  (cor_busy),
    .done_o  (cor_done),
    .phase_o (cor_phase)
  );

  always_ff @(posedge clk_i) begin
    if (take_o) s_q <= sample_i;
    if (cor_done) phase_q <= cor_phase;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
      step_q  <= ST_POS;
      u_q     <= '0;
      x_q     <= '0;
      d_q     <= '0;
      acc_q   <= '0;
    end else begin
      case (state_q)
        IDLE: begin
          if (avail_i) begin
            if (restart_i) begin
              u_q <= '0;
              x_q <= '0;
              d_q <= '0;
            end
            step_q  <= ST_POS;
            state_q <= ISSUE;
          end
        end
        ISSUE: state_q <= WAIT;
        WAIT: begin
          if (mul_done) begin
            state_q <= ISSUE;
            case (step_q)
              ST_POS:    begin u_q <= sat_add(u_q, mul_p);     step_q <= ST_DAMP;   end
              ST_DAMP:   begin acc_q <= sat_sub(s_q, mul_p);   step_q <= ST_SPRING; end
              ST_SPRING: begin acc_q <= sat_sub(acc_q, mul_p); step_q <= ST_VEL;    end
              ST_VEL:    begin x_q <= sat_add(x_q, mul_p);     step_q <= ST_LEAK;   end
              ST_LEAK:   begin acc_q <= mul_p;                 step_q <= ST_INTEG;  end
              ST_INTEG:  begin d_q <= sat_add(d_q, mul_p);     step_q <= ST_GAIN;   end
              ST_GAIN:   begin acc_q <= mul_p;                 state_q <= CSTART;   end
              default:   state_q <= IDLE;
            endcase
          end
        end
        CSTART: state_q <= CWAIT;
        CWAIT: begin
          if (cor_done) state_q <= OUT;
        end
        OUT: begin
          if (space_i) state_q <= IDLE;
        end
        default: state_q <= IDLE;
      endcase
    end
  end

  a_cor_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cor_start |-> !cor_busy)
    else $error("angle unit started while busy");

  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_o |=> (state_q == ISSUE && step_q == ST_POS))
    else $error("request taken without starting the first step");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == WAIT))
    else $error("multiplier result arrived outside of a wait");

endmodule

>>> src/oscillator_phase_estimator.sv
// Oscillator phase estimator. Each request carries one signed Q16.16 sample
// and a restart flag; restart clears the position, velocity and integrator
// state before the sample is applied. The block advances a damped linear
// oscillator by one semi-implicit Euler step (saturating Q16.32 state) and
// returns one phase value per request in signed Q3.13, clamped to -pi..pi.
// A two-entry input queue takes requests (push/full) and a two-entry result
// queue hands them out (empty/pop), so both sides may stall independently.
// Items are processed one at a time. The seven coefficient products share
// one multiplier that builds each product from 32 by 32 partial products.
// The angle unit then shifts both operands right one bit at a time while
// the larger exceeds 30 bits (by up to STATE_BITS-30 bits), then runs
// ANGLE_ITERATIONS rotation steps; the rotations are skipped when either
// operand is zero. Configuration registers are to be written through
// cfg_we_i, cfg_idx_i and cfg_data_i only while the block is idle; the
// block itself does not enforce this. Indexes beyond the last register
// are ignored.
module oscillator_phase_estimator #(
  parameter int ANGLE_ITERATIONS = ope_pkg::ANGLE_ITERATIONS_DEF,
  parameter int STATE_BITS       = ope_pkg::STATE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ope_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ope_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            push,
  output logic                            full,
  input  logic signed [31:0]              sample_i,
  input  logic                            restart_i,
  output logic                            empty,
  input  logic                            pop,
  output logic signed [15:0]              phase_o
);

  ope_pkg::cfg_t cfg_q;

  logic                         fr_avail, fr_take, fr_restart;
  logic signed [STATE_BITS-1:0] fr_sample;
  logic                         res_valid, res_space;
  logic signed [15:0]           res_phase;

  // Result queue: two entries of phase.
  logic signed [15:0] res_mem_q [2];
  logic               res_wr_q, res_rd_q;
  logic [1:0]         res_cnt_q;
  logic               res_pop;

  // Register writes; an index past the list leaves everything unchanged.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.damping         <= ope_pkg::DAMPING_RST;
      cfg_q.omega_squared   <= ope_pkg::OMEGA_SQ_RST;
      cfg_q.inverse_mu      <= ope_pkg::INV_MU_RST;
      cfg_q.time_step       <= ope_pkg::TIME_STEP_RST;
      cfg_q.quadrature_gain <= ope_pkg::QUAD_GAIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ope_pkg::CFG_DAMPING:       cfg_q.damping         <= cfg_data_i;
        ope_pkg::CFG_OMEGA_SQUARED: cfg_q.omega_squared   <= cfg_data_i;
        ope_pkg::CFG_INVERSE_MU:    cfg_q.inverse_mu      <= cfg_data_i;
        ope_pkg::CFG_TIME_STEP:     cfg_q.time_step       <= cfg_data_i;
        ope_pkg::CFG_QUAD_GAIN:     cfg_q.quadrature_gain <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The front queues requests and rescales each sample to the state format.
  ope_front #(.STATE_BITS(STATE_BITS)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .sample_i  (sample_i),
    .restart_i (restart_i),
    .avail_o   (fr_avail),
    .take_i    (fr_take),
    .sample_o  (fr_sample),
    .restart_o (fr_restart)
  );

  // The back runs the oscillator update and the phase computation.
  ope_core #(.ANGLE_ITERATIONS(ANGLE_ITERATIONS), .STATE_BITS(STATE_BITS)) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .avail_i     (fr_avail),
    .sample_i    (fr_sample),
    .restart_i   (fr_restart),
    .take_o      (fr_take),
    .space_i     (res_space),
    .res_valid_o (res_valid),
    .phase_o     (res_phase)
  );

  assign res_space = (res_cnt_q != 2'd2);
  assign empty     = (res_cnt_q == 2'd0);
  assign res_pop   = pop && !empty;
  assign phase_o   = res_mem_q[res_rd_q];

  always_ff @(posedge clk_i) begin
    if (res_valid) res_mem_q[res_wr_q] <= res_phase;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_wr_q  <= 1'b0;
      res_rd_q  <= 1'b0;
      res_cnt_q <= 2'd0;
    end else begin
      if (res_valid) res_wr_q <= ~res_wr_q;
      if (res_pop) res_rd_q <= ~res_rd_q;
      res_cnt_q <= res_cnt_q + 2'(res_valid) - 2'(res_pop);
    end
  end

  a_res_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> res_space)
    else $error("result written into a full queue");

  a_res_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_cnt_q != 2'd3)
    else $error("result queue count out of range");

  a_res_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !res_pop) |=> !empty)
    else $error("result lost on its way into the queue");

endmodule
